[hdl/ppdc_pkg.sv]
// Shared types and constants for the push/pop discipline checker.
// Used by ppdc_cell, ppdc_ctrl and push_pop_discipline_checker. No dependencies.
`default_nettype none

package ppdc_pkg;

    localparam int DEPTH   = 1024;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = IDX_W + 1;
    localparam int VALUE_W = 32;

    // Operation codes of a request (code 3 leaves the state alone)
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    // Verdict codes
    typedef enum logic [2:0] {
        V_IMPOSSIBLE = 3'd0,
        V_NOT_SURE   = 3'd1,
        V_STACK      = 3'd2,
        V_QUEUE      = 3'd3,
        V_PRIO       = 3'd4
    } t_verdict;

    // One entry of each shadow structure held by a cell
    typedef struct packed {
        logic signed [VALUE_W-1:0] stk;
        logic signed [VALUE_W-1:0] fifo;
        logic signed [VALUE_W-1:0] prio;
    } t_slot;

    // Broadcast command from the controller to every cell
    typedef struct packed {
        logic                      push_stk;
        logic                      pop_stk;
        logic                      push_fifo;
        logic                      pop_fifo;
        logic                      push_prio;
        logic                      pop_prio;
        logic signed [VALUE_W-1:0] key;
        logic [CNT_W-1:0]          fifo_cnt;
        logic [CNT_W-1:0]          prio_cnt;
    } t_cmd;

endpackage

`default_nettype wire

[hdl/push_pop_discipline_checker.sv]
// Top level of the push/pop discipline checker: controller plus a chain of
// DEPTH shadow cells. Depends on ppdc_pkg, ppdc_cell and ppdc_ctrl.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request: i_operation
//   (push, pop expecting i_value, clear) and i_value (signed). Output channel
//   (o_out_valid / i_out_ready) carries one result per request: o_verdict
//   (impossible, not sure, stack, queue, priority queue) and o_overflow, a
//   sticky flag for a push dropped because a shadow store was full.
//   The result is registered and appears in the cycle after acceptance.
//   Throughput is one request per cycle while results are taken; the chain of cells updates every
//   entry of all three shadows in parallel on each accepted request, so no
//   sift loop stands in the way.
//   The result register parts the two sides: while the receiver stalls with
//   a result waiting, o_in_ready drops and no request is taken; when the
//   result is taken, a new request may be accepted in that same cycle.
//   Synchronous active-low reset empties all three shadows, marks every
//   discipline possible, clears the overflow flag and the result valid bit.
//   No clearing pass is needed after reset.
`default_nettype none

module push_pop_discipline_checker (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire [1:0]                          i_operation,
    input  wire signed [ppdc_pkg::VALUE_W-1:0] i_value,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic [2:0]                         o_verdict,
    output logic                               o_overflow
);

    ppdc_pkg::t_cmd  w_cmd;
    ppdc_pkg::t_slot w_slot [ppdc_pkg::DEPTH];
    logic            w_ge   [ppdc_pkg::DEPTH];
    ppdc_pkg::t_slot w_key_slot;

    // Feed the key into the first cell as its upstream neighbor
    assign w_key_slot = '{stk: i_value, fifo: i_value, prio: i_value};

    ppdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_head      (w_slot[0]),
        .o_cmd       (w_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_verdict   (o_verdict),
        .o_overflow  (o_overflow)
    );

    // Build the chain; cell 0 holds stack top, queue head and maximum
    for (genvar g = 0; g < ppdc_pkg::DEPTH; g++) begin : g_cell
        ppdc_pkg::t_slot w_prev;
        ppdc_pkg::t_slot w_next;
        logic            w_prev_ge;

        if (g == 0) begin : g_first
            assign w_prev    = w_key_slot;
            assign w_prev_ge = 1'b1;
        end else begin : g_mid
            assign w_prev    = w_slot[g-1];
            assign w_prev_ge = w_ge[g-1];
        end

        if (g == ppdc_pkg::DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_slot[g+1];
        end

        ppdc_cell u_cell (
            .i_clk     (i_clk),
            .i_cmd     (w_cmd),
            .i_idx     (ppdc_pkg::IDX_W'(g)),
            .i_prev    (w_prev),
            .i_prev_ge (w_prev_ge),
            .i_next    (w_next),
            .o_slot    (w_slot[g]),
            .o_ge      (w_ge[g])
        );
    end

endmodule

`default_nettype wire

[hdl/ppdc_cell.sv]
// One cell of the shadow chain: holds one stack, one queue and one sorted
// priority entry and shifts them with its neighbors. Depends on ppdc_pkg.
`default_nettype none

module ppdc_cell (
    input  wire                         i_clk,
    input  ppdc_pkg::t_cmd              i_cmd,
    input  wire [ppdc_pkg::IDX_W-1:0]   i_idx,
    input  ppdc_pkg::t_slot             i_prev,
    input  wire                         i_prev_ge,
    input  ppdc_pkg::t_slot             i_next,
    output ppdc_pkg::t_slot             o_slot,
    output logic                        o_ge
);

    ppdc_pkg::t_slot r_slot;
    ppdc_pkg::t_slot n_slot;
    logic            w_used;

    // Mark a live priority entry that is not below the key
    assign w_used = {1'b0, i_idx} < i_cmd.prio_cnt;
    assign o_ge   = w_used && ($signed(r_slot.prio) >= $signed(i_cmd.key));
    assign o_slot = r_slot;

    // Shift the stack: push moves entries away from the top, pop toward it
    always_comb begin
        n_slot = r_slot;
        if (i_cmd.push_stk) begin
            n_slot.stk = i_prev.stk;
        end else if (i_cmd.pop_stk) begin
            n_slot.stk = i_next.stk;
        end

        // Queue: write at the tail cell, advance toward the head on pop
        if (i_cmd.push_fifo) begin
            if ({1'b0, i_idx} == i_cmd.fifo_cnt) begin
                n_slot.fifo = i_cmd.key;
            end
        end else if (i_cmd.pop_fifo) begin
            n_slot.fifo = i_next.fifo;
        end

        // Priority: keep if not below key, take key at the boundary, else shift
        if (i_cmd.push_prio) begin
            if (o_ge) begin
                n_slot.prio = r_slot.prio;
            end else if (i_prev_ge) begin
                n_slot.prio = i_cmd.key;
            end else begin
                n_slot.prio = i_prev.prio;
            end
        end else if (i_cmd.pop_prio) begin
            n_slot.prio = i_next.prio;
        end
    end

    // Hold entry contents; no reset needed for payload
    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

endmodule

`default_nettype wire

[hdl/ppdc_ctrl.sv]
// Controller: counts, discipline flags, overflow flag, verdict and handshake.
// Drives the broadcast command of the cell chain. Depends on ppdc_pkg.
`default_nettype none

module ppdc_ctrl (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire [1:0]                         i_operation,
    input  wire signed [ppdc_pkg::VALUE_W-1:0] i_value,
    input  ppdc_pkg::t_slot                   i_head,
    output ppdc_pkg::t_cmd                    o_cmd,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic [2:0]                        o_verdict,
    output logic                              o_overflow
);

    localparam logic [ppdc_pkg::CNT_W-1:0] FULL = ppdc_pkg::CNT_W'(ppdc_pkg::DEPTH);

    logic [ppdc_pkg::CNT_W-1:0] r_stk_cnt, n_stk_cnt;
    logic [ppdc_pkg::CNT_W-1:0] r_fifo_cnt, n_fifo_cnt;
    logic [ppdc_pkg::CNT_W-1:0] r_prio_cnt, n_prio_cnt;
    logic                       r_lifo, n_lifo;
    logic                       r_fifo, n_fifo;
    logic                       r_prio, n_prio;
    logic                       r_ovf, n_ovf;
    logic                       r_out_valid;
    ppdc_pkg::t_verdict         r_verdict, n_verdict;
    logic                       r_ovf_out;
    logic                       w_accept;

    // Take a request whenever the result register is free or being drained
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;
    assign o_overflow  = r_ovf_out;

    // Decode the request into count updates and cell shifts
    always_comb begin
        n_stk_cnt  = r_stk_cnt;
        n_fifo_cnt = r_fifo_cnt;
        n_prio_cnt = r_prio_cnt;
        n_lifo     = r_lifo;
        n_fifo     = r_fifo;
        n_prio     = r_prio;
        n_ovf      = r_ovf;
        o_cmd           = '0;
        o_cmd.key       = i_value;
        o_cmd.fifo_cnt  = r_fifo_cnt;
        o_cmd.prio_cnt  = r_prio_cnt;
        if (w_accept) begin
            case (i_operation)
                ppdc_pkg::OP_PUSH: begin
                    if (r_lifo) begin
                        if (r_stk_cnt != FULL) begin
                            o_cmd.push_stk = 1'b1;
                            n_stk_cnt      = r_stk_cnt + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    if (r_fifo) begin
                        if (r_fifo_cnt != FULL) begin
                            o_cmd.push_fifo = 1'b1;
                            n_fifo_cnt      = r_fifo_cnt + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    if (r_prio) begin
                        if (r_prio_cnt != FULL) begin
                            o_cmd.push_prio = 1'b1;
                            n_prio_cnt      = r_prio_cnt + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                end
                ppdc_pkg::OP_POP: begin
                    if (r_lifo) begin
                        if (r_stk_cnt == '0 || i_head.stk != i_value) begin
                            n_lifo = 1'b0;
                        end else begin
                            o_cmd.pop_stk = 1'b1;
                            n_stk_cnt     = r_stk_cnt - 1'b1;
                        end
                    end
                    if (r_fifo) begin
                        if (r_fifo_cnt == '0 || i_head.fifo != i_value) begin
                            n_fifo = 1'b0;
                        end else begin
                            o_cmd.pop_fifo = 1'b1;
                            n_fifo_cnt     = r_fifo_cnt - 1'b1;
                        end
                    end
                    if (r_prio) begin
                        if (r_prio_cnt == '0 || i_head.prio != i_value) begin
                            n_prio = 1'b0;
                        end else begin
                            o_cmd.pop_prio = 1'b1;
                            n_prio_cnt     = r_prio_cnt - 1'b1;
                        end
                    end
                end
                ppdc_pkg::OP_CLEAR: begin
                    n_stk_cnt  = '0;
                    n_fifo_cnt = '0;
                    n_prio_cnt = '0;
                    n_lifo     = 1'b1;
                    n_fifo     = 1'b1;
                    n_prio     = 1'b1;
                    n_ovf      = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Form the verdict from the updated flags
    always_comb begin
        case ({n_lifo, n_fifo, n_prio})
            3'b000:  n_verdict = ppdc_pkg::V_IMPOSSIBLE;
            3'b100:  n_verdict = ppdc_pkg::V_STACK;
            3'b010:  n_verdict = ppdc_pkg::V_QUEUE;
            3'b001:  n_verdict = ppdc_pkg::V_PRIO;
            default: n_verdict = ppdc_pkg::V_NOT_SURE;
        endcase
    end

    // Advance control state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stk_cnt   <= '0;
            r_fifo_cnt  <= '0;
            r_prio_cnt  <= '0;
            r_lifo      <= 1'b1;
            r_fifo      <= 1'b1;
            r_prio      <= 1'b1;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_stk_cnt  <= n_stk_cnt;
            r_fifo_cnt <= n_fifo_cnt;
            r_prio_cnt <= n_prio_cnt;
            r_lifo     <= n_lifo;
            r_fifo     <= n_fifo;
            r_prio     <= n_prio;
            r_ovf      <= n_ovf;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the result payload of an accepted request
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_verdict <= n_verdict;
            r_ovf_out <= n_ovf;
        end
    end

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for push_pop_discipline_checker: streams traces of push,
// pop and clear requests and checks every verdict against a shadow predictor.
// Depends on ppdc_pkg and the checker RTL; needs no other files.
`timescale 1ns / 1ps

module tb_top;

    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         SETTLE_CYCLES  = 20;
    localparam logic [1:0] OP_UNUSED      = 2'd3;

    typedef logic signed [ppdc_pkg::VALUE_W-1:0] t_val;

    typedef struct {
        logic [1:0] op;
        t_val       val;
    } t_request;

    typedef struct {
        ppdc_pkg::t_verdict verdict;
        logic               overflow;
    } t_outcome;

    // Discipline a generated trace follows when it pops
    typedef enum {FOLLOW_STACK, FOLLOW_QUEUE, FOLLOW_HEAP} t_follow;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [1:0] i_operation = '0;
    t_val       i_value     = '0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [2:0] o_verdict;
    logic       o_overflow;

    t_request req_q[$];
    t_outcome verdict_q[$];
    int       n_queued       = 0;
    int       n_accepted     = 0;
    int       n_errors       = 0;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    int       quiet_cycles   = 0;

    // Shadow copies of the three structures
    t_val                       stk_mem[ppdc_pkg::DEPTH];
    logic [ppdc_pkg::CNT_W-1:0] stk_cnt;
    t_val                       ring_mem[ppdc_pkg::DEPTH];
    logic [ppdc_pkg::IDX_W-1:0] ring_head;
    logic [ppdc_pkg::CNT_W-1:0] ring_cnt;
    t_val                       heap_mem[ppdc_pkg::DEPTH];
    logic [ppdc_pkg::CNT_W-1:0] heap_cnt;
    logic                       lifo_ok;
    logic                       fifo_ok;
    logic                       prio_ok;
    logic                       ovf_seen;

    push_pop_discipline_checker u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_verdict   (o_verdict),
        .o_overflow  (o_overflow)
    );

    always #4 i_clk = ~i_clk;

    // Empty every shadow and mark all disciplines possible
    function automatic void shadow_clear();
        stk_cnt   = '0;
        ring_head = '0;
        ring_cnt  = '0;
        heap_cnt  = '0;
        lifo_ok   = 1'b1;
        fifo_ok   = 1'b1;
        prio_ok   = 1'b1;
        ovf_seen  = 1'b0;
    endfunction

    // Apply one request to the shadows and return the verdict it yields
    function automatic t_outcome classify_request(logic [1:0] op, t_val val);
        t_outcome                   res;
        logic [ppdc_pkg::IDX_W-1:0] pos;
        int                         top;
        int                         fits;
        case (op)
            ppdc_pkg::OP_PUSH: begin
                if (lifo_ok) begin
                    if (stk_cnt < ppdc_pkg::DEPTH) begin
                        stk_mem[stk_cnt] = val;
                        stk_cnt++;
                    end else begin
                        ovf_seen = 1'b1;
                    end
                end
                if (fifo_ok) begin
                    if (ring_cnt < ppdc_pkg::DEPTH) begin
                        pos = ring_head + ring_cnt[ppdc_pkg::IDX_W-1:0];
                        ring_mem[pos] = val;
                        ring_cnt++;
                    end else begin
                        ovf_seen = 1'b1;
                    end
                end
                if (prio_ok) begin
                    if (heap_cnt < ppdc_pkg::DEPTH) begin
                        heap_mem[heap_cnt] = val;
                        heap_cnt++;
                    end else begin
                        ovf_seen = 1'b1;
                    end
                end
            end
            ppdc_pkg::OP_POP: begin
                if (lifo_ok) begin
                    if (stk_cnt == 0 || stk_mem[stk_cnt - 1] != val) lifo_ok = 1'b0;
                    else stk_cnt--;
                end
                if (fifo_ok) begin
                    if (ring_cnt == 0 || ring_mem[ring_head] != val) begin
                        fifo_ok = 1'b0;
                    end else begin
                        ring_head++;
                        ring_cnt--;
                    end
                end
                if (prio_ok) begin
                    // the heap is kept as an unordered bag: only its maximum matters
                    top = 0;
                    for (int k = 1; k < heap_cnt; k++)
                        if (heap_mem[k] > heap_mem[top]) top = k;
                    if (heap_cnt == 0 || heap_mem[top] != val) begin
                        prio_ok = 1'b0;
                    end else begin
                        heap_mem[top] = heap_mem[heap_cnt - 1];
                        heap_cnt--;
                    end
                end
            end
            ppdc_pkg::OP_CLEAR: shadow_clear();
            default: ;
        endcase
        fits = int'(lifo_ok) + int'(fifo_ok) + int'(prio_ok);
        if (fits == 0) res.verdict = ppdc_pkg::V_IMPOSSIBLE;
        else if (fits > 1) res.verdict = ppdc_pkg::V_NOT_SURE;
        else if (lifo_ok) res.verdict = ppdc_pkg::V_STACK;
        else if (fifo_ok) res.verdict = ppdc_pkg::V_QUEUE;
        else res.verdict = ppdc_pkg::V_PRIO;
        res.overflow = ovf_seen;
        return res;
    endfunction

    function automatic void add_req(logic [1:0] op, t_val val);
        t_request r;
        r.op  = op;
        r.val = val;
        req_q.push_back(r);
        n_queued++;
    endfunction

    // Narrow values collide often, so several disciplines stay possible
    function automatic t_val rand_val(bit wide);
        if (wide) return t_val'($urandom);
        return t_val'($urandom_range(6)) - 3;
    endfunction

    // Extend a trace that obeys one discipline, salted with noise
    task automatic gen_trace(t_follow mode, int len, bit wide, ref t_val held[$]);
        t_val v;
        int   r;
        int   pick;
        for (int n = 0; n < len; n++) begin
            r = $urandom_range(99);
            if (r < 2) begin
                add_req(OP_UNUSED, rand_val(1'b1));
            end else if (r < 4) begin
                add_req(ppdc_pkg::OP_POP, rand_val(wide));
            end else if (r < 5) begin
                add_req(ppdc_pkg::OP_CLEAR, rand_val(1'b1));
                held.delete();
            end else if (held.size() == 0 && r < 15) begin
                add_req(ppdc_pkg::OP_POP, rand_val(wide));
            end else if (held.size() == 0 || r < 55) begin
                v = rand_val(wide);
                if (held.size() < ppdc_pkg::DEPTH) held.push_back(v);
                add_req(ppdc_pkg::OP_PUSH, v);
            end else begin
                pick = 0;
                if (mode == FOLLOW_STACK) begin
                    pick = held.size() - 1;
                end else if (mode == FOLLOW_HEAP) begin
                    for (int k = 1; k < held.size(); k++)
                        if (held[k] > held[pick]) pick = k;
                end
                add_req(ppdc_pkg::OP_POP, held[pick]);
                held.delete(pick);
            end
        end
    endtask

    // Fill every store past its depth, then keep popping and pushing
    task automatic gen_fill();
        t_val held[$];
        t_val v;
        add_req(ppdc_pkg::OP_CLEAR, 0);
        for (int n = 0; n < ppdc_pkg::DEPTH + 6; n++) begin
            v = rand_val(1'b1);
            if (held.size() < ppdc_pkg::DEPTH) held.push_back(v);
            add_req(ppdc_pkg::OP_PUSH, v);
        end
        gen_trace(t_follow'($urandom_range(2)), 40, 1'b1, held);
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || verdict_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int n_items, bit with_fill);
        t_val held[$];
        int   stop;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (with_fill) gen_fill();
        stop = n_queued + n_items;
        while (n_queued < stop) begin
            held.delete();
            if ($urandom_range(9) != 0) add_req(ppdc_pkg::OP_CLEAR, rand_val(1'b1));
            gen_trace(t_follow'($urandom_range(2)), $urandom_range(4, 60),
                      $urandom_range(1) == 1, held);
        end
        wait_drained();
    endtask

    // Drive requests from the pending queue; predict each one on acceptance
    always @(posedge i_clk) begin
        t_request nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            shadow_clear();
        end else begin
            if (i_in_valid && o_in_ready) begin
                verdict_q.push_back(classify_request(i_operation, i_value));
                n_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = req_q.pop_front();
                    i_in_valid  <= 1'b1;
                    i_operation <= nxt.op;
                    i_value     <= nxt.val;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result with the oldest predicted verdict
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result: verdict %0d overflow %0b",
                         $time, o_verdict, o_overflow);
                n_errors++;
            end else begin
                want = verdict_q.pop_front();
                if (o_verdict !== want.verdict) begin
                    $display("%0t: verdict mismatch: expected %0d (%s) actual %0d",
                             $time, want.verdict, want.verdict.name(), o_verdict);
                    n_errors++;
                end
                if (o_overflow !== want.overflow) begin
                    $display("%0t: overflow mismatch: expected %0b actual %0b",
                             $time, want.overflow, o_overflow);
                    n_errors++;
                end
            end
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        send_idle_pct  = 32;
        recv_stall_pct = 59;

        // pop on an empty trace rules out every discipline
        add_req(ppdc_pkg::OP_POP, 7);
        // unused code leaves the state alone
        add_req(OP_UNUSED, -1);
        add_req(ppdc_pkg::OP_CLEAR, 0);
        // extreme values, then pops that only a stack explains
        add_req(ppdc_pkg::OP_PUSH, 32'sh7FFF_FFFF);
        add_req(ppdc_pkg::OP_PUSH, 32'sh8000_0000);
        add_req(ppdc_pkg::OP_PUSH, 0);
        add_req(ppdc_pkg::OP_PUSH, -1);
        add_req(ppdc_pkg::OP_POP, -1);
        add_req(ppdc_pkg::OP_POP, 0);
        add_req(ppdc_pkg::OP_PUSH, 5);
        add_req(ppdc_pkg::OP_POP, 9);
        // pop with every discipline already failed
        add_req(ppdc_pkg::OP_POP, 5);
        // queue and heap agree first, then only the heap fits
        add_req(ppdc_pkg::OP_CLEAR, -7);
        add_req(ppdc_pkg::OP_PUSH, 3);
        add_req(ppdc_pkg::OP_PUSH, 1);
        add_req(ppdc_pkg::OP_POP, 3);
        add_req(ppdc_pkg::OP_PUSH, 2);
        add_req(ppdc_pkg::OP_POP, 2);
        // only the queue fits, then it fails too
        add_req(ppdc_pkg::OP_CLEAR, 0);
        add_req(ppdc_pkg::OP_PUSH, 1);
        add_req(ppdc_pkg::OP_PUSH, 2);
        add_req(ppdc_pkg::OP_POP, 1);
        add_req(ppdc_pkg::OP_POP, 32'sh8000_0000);
        add_req(OP_UNUSED, 32'sh7FFF_FFFF);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        // the fill trace of the last phase carries most of the items
        run_phase(32, 59, 70, 1'b0);
        run_phase(59, 32, 70, 1'b0);
        run_phase(0, 0, 70, 1'b1);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && verdict_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/ppdc_pkg.sv
hdl/ppdc_cell.sv
hdl/ppdc_ctrl.sv
hdl/push_pop_discipline_checker.sv
bench/tb_top.sv
